// ===== sv/sps_pkg.sv =====
`timescale 1ns / 1ps

package sps_pkg;

   // scratchpad geometry
   localparam int MEM_BYTES = 16384;
   localparam int LANES     = 8;
   localparam int LANE_W    = 3;
   localparam int OFF_W     = $clog2(MEM_BYTES);
   localparam int ROW_W     = OFF_W - LANE_W;
   localparam int ROWS      = (MEM_BYTES + LANES - 1) / LANES;

   localparam int ADDR_W = 32;
   localparam int DATA_W = 64;
   localparam int SPAN_W = ADDR_W + 1;

   // front/back queue
   localparam int QDEPTH = 2;
   localparam int QPTR_W = 1;
   localparam int QCNT_W = 2;

   // register file
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_BASE_ADDRESS = 1'b0;

   // command and size codes
   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   localparam logic [1:0] WC_1B = 2'd0;
   localparam logic [1:0] WC_2B = 2'd1;
   localparam logic [1:0] WC_4B = 2'd2;
   localparam logic [1:0] WC_8B = 2'd3;

   typedef struct packed {
      logic                  ok;
      logic                  wr;
      logic [1:0]            code;
      logic [LANE_W-1:0]     lane;
      logic [ROW_W-1:0]      row;
      logic [LANES-1:0]      en;
      logic [DATA_W-1:0]     wdata;   // bytes already placed on their banks
   } qent_type;

   typedef struct packed {
      logic q_full;
      logic clearing;
   } fstat_type;

   function automatic logic [LANES-1:0] byte_mask(input logic [1:0] code);
      logic [LANES-1:0] m;
      case (code)
         WC_1B:   m = 8'h01;
         WC_2B:   m = 8'h03;
         WC_4B:   m = 8'h0f;
         WC_8B:   m = 8'hff;
         default: m = 8'h00;
      endcase
      return m;
   endfunction

   function automatic logic [3:0] span_len(input logic [1:0] code);
      logic [3:0] n;
      case (code)
         WC_1B:   n = 4'd1;
         WC_2B:   n = 4'd2;
         WC_4B:   n = 4'd4;
         WC_8B:   n = 4'd8;
         default: n = 4'd0;
      endcase
      return n;
   endfunction

endpackage

// ===== sv/sps_front.sv =====
`timescale 1ns / 1ps

module sps_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_cmd,
   input  logic [1:0]                  req_width_code,
   input  logic [sps_pkg::ADDR_W-1:0]  req_address,
   input  logic [sps_pkg::DATA_W-1:0]  req_write_data,
   input  logic [sps_pkg::ADDR_W-1:0]  base_address,
   input  sps_pkg::fstat_type          stat,
   output logic                        push,
   output sps_pkg::qent_type           push_ent
);
   import sps_pkg::*;

   logic              f_v_ff, f_v_in;
   logic              f_cmd_ff;
   logic [1:0]        f_code_ff;
   logic [ADDR_W-1:0] f_addr_ff;
   logic [DATA_W-1:0] f_wdata_ff;

   logic              accept;
   logic              below;
   logic [ADDR_W-1:0] diff;
   logic [SPAN_W-1:0] span_end;
   logic              in_window;
   logic [LANE_W-1:0] lane;
   logic [LANES-1:0]  mask;

   // front register stalls only if the queue is full; busy is also high while clearing
   assign busy   = stat.clearing | (f_v_ff & stat.q_full);
   assign accept = start & ~busy;
   assign push   = f_v_ff & ~stat.q_full;
   assign f_v_in = accept | (f_v_ff & stat.q_full);

   always_ff @(posedge clock) begin
      if (reset) begin
         f_v_ff <= 1'b0;
      end else begin
         f_v_ff <= f_v_in;
      end
      if (accept) begin
         f_cmd_ff   <= req_cmd;
         f_code_ff  <= req_width_code;
         f_addr_ff  <= req_address;
         f_wdata_ff <= req_write_data;
      end
   end

   // window check: base <= addr and (addr - base) + len <= MEM_BYTES
   assign below     = f_addr_ff < base_address;
   assign diff      = f_addr_ff - base_address;
   assign span_end  = {1'b0, diff} + SPAN_W'(span_len(f_code_ff));
   assign in_window = ~below & (span_end <= SPAN_W'(MEM_BYTES));
   assign lane      = diff[LANE_W-1:0];
   assign mask      = byte_mask(f_code_ff);

   always_comb begin
      logic [LANE_W-1:0] src;
      push_ent.ok   = in_window;
      push_ent.wr   = (f_cmd_ff == CMD_WRITE);
      push_ent.code = f_code_ff;
      push_ent.lane = lane;
      push_ent.row  = diff[OFF_W-1:LANE_W];
      push_ent.en   = '0;
      push_ent.wdata = '0;
      for (int b = 0; b < LANES; b++) begin
         src = LANE_W'(b) - lane;
         push_ent.en[b] = mask[src] & in_window;
         push_ent.wdata[b*8 +: 8] = f_wdata_ff[src*8 +: 8];
      end
   end

endmodule

// ===== sv/sps_queue.sv =====
`timescale 1ns / 1ps

module sps_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  sps_pkg::qent_type  push_ent,
   input  logic               pop,
   output logic               empty,
   output logic               full,
   output sps_pkg::qent_type  head
);
   import sps_pkg::*;

   qent_type          slot_ff [QDEPTH];
   logic [QPTR_W-1:0] wptr_ff, wptr_in;
   logic [QPTR_W-1:0] rptr_ff, rptr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              do_pop;

   assign empty  = (cnt_ff == '0);
   assign full   = (cnt_ff == QCNT_W'(QDEPTH));
   assign head   = slot_ff[rptr_ff];
   assign do_pop = pop & ~empty;

   always_comb begin
      wptr_in = push   ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in = do_pop ? rptr_ff + 1'b1 : rptr_ff;
      cnt_in  = cnt_ff + QCNT_W'(push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
      if (push) begin
         slot_ff[wptr_ff] <= push_ent;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full & ~do_pop |-> ~push)
      else $error("queue push while full");

endmodule

// ===== sv/sps_back.sv =====
`timescale 1ns / 1ps

module sps_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_empty,
   input  sps_pkg::qent_type           head,
   output logic                        pop,
   output logic                        clearing,
   output logic                        rsp_valid,
   output logic                        rsp_ok,
   output logic [sps_pkg::DATA_W-1:0]  rsp_read_data
);
   import sps_pkg::*;

   logic              clr_active_ff, clr_active_in;
   logic [ROW_W-1:0]  clr_row_ff, clr_row_in;

   logic              issue;
   logic [ROW_W-1:0]  row_next;
   logic [ROW_W-1:0]  bank_row [LANES];
   logic [7:0]        rd_ff [LANES];

   // access stage
   logic              a_v_ff;
   logic              a_ok_ff;
   logic              a_wr_ff;
   logic [1:0]        a_code_ff;
   logic [LANE_W-1:0] a_lane_ff;

   // result stage
   logic              rsp_valid_ff;
   logic              rsp_ok_ff;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;

   assign clearing = clr_active_ff;
   assign issue    = ~q_empty & ~clr_active_ff;
   assign pop      = issue;

   // zero sweep after reset, one row of all banks per cycle
   always_comb begin
      clr_active_in = clr_active_ff;
      clr_row_in    = clr_row_ff;
      if (clr_active_ff) begin
         clr_row_in = clr_row_ff + 1'b1;
         if (clr_row_ff == ROW_W'(ROWS - 1)) begin
            clr_active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_row_ff    <= '0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_row_ff    <= clr_row_in;
      end
   end

   // banks below the start lane hold the wrapped bytes in the next row
   assign row_next = head.row + 1'b1;

   for (genvar b = 0; b < LANES; b++) begin : g_bank
      logic [7:0]       mem [ROWS];
      logic             we;
      logic [ROW_W-1:0] waddr;
      logic [7:0]       wbyte;

      assign bank_row[b] = (LANE_W'(b) < head.lane) ? row_next : head.row;
      assign we    = clr_active_ff | (issue & head.wr & head.en[b]);
      assign waddr = clr_active_ff ? clr_row_ff : bank_row[b];
      assign wbyte = clr_active_ff ? 8'h00 : head.wdata[b*8 +: 8];

      always_ff @(posedge clock) begin
         if (we) begin
            mem[waddr] <= wbyte;
         end
         rd_ff[b] <= mem[bank_row[b]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else begin
         a_v_ff <= issue;
      end
      if (issue) begin
         a_ok_ff   <= head.ok;
         a_wr_ff   <= head.wr;
         a_code_ff <= head.code;
         a_lane_ff <= head.lane;
      end
   end

   // rotate bank bytes back to little-endian order, keep only the span of an accepted read
   always_comb begin
      logic [LANES-1:0]  keep;
      logic [LANE_W-1:0] src;
      keep = byte_mask(a_code_ff) & {LANES{a_ok_ff & ~a_wr_ff}};
      rsp_data_in = '0;
      for (int i = 0; i < LANES; i++) begin
         src = a_lane_ff + LANE_W'(i);
         rsp_data_in[i*8 +: 8] = keep[i] ? rd_ff[src] : 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= a_v_ff;
      end
      if (a_v_ff) begin
         rsp_ok_ff   <= a_ok_ff;
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_ok        = rsp_ok_ff;
   assign rsp_read_data = rsp_data_ff;

   a_issue_to_rsp: assert property (@(posedge clock) disable iff (reset)
      issue |-> ##2 rsp_valid_ff)
      else $error("issued access produced no result");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff & ~rsp_ok_ff |-> rsp_data_ff == '0)
      else $error("rejected access returned data");

   a_no_issue_in_clear: assert property (@(posedge clock) disable iff (reset)
      clr_active_ff |=> ~a_v_ff)
      else $error("access issued during clearing sweep");

   a_reject_no_write: assert property (@(posedge clock) disable iff (reset)
      issue & ~head.ok |-> head.en == '0)
      else $error("rejected access has byte enables");

endmodule

// ===== sv/byte_addressed_scratchpad_ram.sv =====
`timescale 1ns / 1ps

// Byte-addressed scratchpad, little-endian, mapped at a programmable base.
// Request channel: drive req_* and raise start; the transfer happens at a
// rising edge with start high and busy low. Each transfer is a read or write
// of 1, 2, 4 or 8 bytes at any byte address; a span that leaves the window
// [base, base + MEM_BYTES) is rejected whole: nothing written, ok = 0,
// read_data = 0. Writes return ok with read_data 0.
// Response channel: rsp_valid is high for exactly one cycle per request,
// after the front register, queue, access and result stages, carrying rsp_ok
// and rsp_read_data. The receiver cannot stall; results arrive in request
// order. Throughput: one request per cycle sustained once the zero sweep is
// done. The front register classifies the request, a two-entry queue decouples
// it from the back end, and the back end accesses eight byte-wide banks (one
// per lane) together, so an unaligned 8-byte access still needs only a single
// bank access. Reset: base_address returns to 0 and the store is swept to zero,
// one row of all eight banks per cycle over MEM_BYTES/8 (2048) rows; busy
// is high during the sweep. CSR writes are accepted at any time.
// CSR: base_address at byte address 0, APB, pready tied high.

module byte_addressed_scratchpad_ram (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_cmd,
   input  logic [1:0]                     req_width_code,
   input  logic [sps_pkg::ADDR_W-1:0]     req_address,
   input  logic [sps_pkg::DATA_W-1:0]     req_write_data,
   // response channel
   output logic                           rsp_valid,
   output logic                           rsp_ok,
   output logic [sps_pkg::DATA_W-1:0]     rsp_read_data,
   // configuration port
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [sps_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [sps_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [sps_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import sps_pkg::*;

   logic [ADDR_W-1:0] base_ff;
   logic              csr_wr;
   logic              csr_hit;

   fstat_type         fstat;
   logic              push;
   qent_type          push_ent;
   logic              q_empty;
   logic              q_full;
   qent_type          q_head;
   logic              pop;
   logic              clearing;

   // register decode: paddr[2] selects the register word
   assign pready  = 1'b1;
   assign csr_hit = (paddr[CSR_ADDR_W-1] == REG_BASE_ADDRESS);
   assign csr_wr  = psel & penable & pwrite & pready;
   assign prdata  = csr_hit ? base_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
      end else if (csr_wr & csr_hit) begin
         base_ff <= pwdata;
      end
   end

   assign fstat.q_full   = q_full;
   assign fstat.clearing = clearing;

   // front: capture and classify (window check, lane placement)
   sps_front u_front (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_cmd        (req_cmd),
      .req_width_code (req_width_code),
      .req_address    (req_address),
      .req_write_data (req_write_data),
      .base_address   (base_ff),
      .stat           (fstat),
      .push           (push),
      .push_ent       (push_ent)
   );

   sps_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_ent (push_ent),
      .pop      (pop),
      .empty    (q_empty),
      .full     (q_full),
      .head     (q_head)
   );

   // back: bank access, zero sweep, result assembly
   sps_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .head          (q_head),
      .pop           (pop),
      .clearing      (clearing),
      .rsp_valid     (rsp_valid),
      .rsp_ok        (rsp_ok),
      .rsp_read_data (rsp_read_data)
   );

endmodule

// ===== test/tb_scratchpad_checker.sv =====
`timescale 1ns / 1ps

module tb_scratchpad_checker
   import sps_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  logic                  req_cmd,
   input  logic [1:0]            req_width_code,
   input  logic [ADDR_W-1:0]     req_address,
   input  logic [DATA_W-1:0]     req_write_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_ok,
   input  logic [DATA_W-1:0]     rsp_read_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   input  logic [CSR_DATA_W-1:0] prdata,
   input  logic                  pready,
   output int                    n_errors,
   output int                    n_pending,
   output int                    n_checked
);

   localparam logic [CSR_ADDR_W-1:0] BASE_OFS = {REG_BASE_ADDRESS, 2'b00};

   typedef struct {
      logic              ok;
      logic [DATA_W-1:0] read_data;
   } access_result_type;

   access_result_type expected_rsp_q[$];
   logic [7:0]        store_img [MEM_BYTES];
   logic [ADDR_W-1:0] base_img = '0;
   int                err_cnt  = 0;
   int                chk_cnt  = 0;

   // applies one access to the shadow store, returns what the block should answer
   function automatic access_result_type apply_access(input logic              cmd,
                                                      input logic [1:0]        code,
                                                      input logic [ADDR_W-1:0] addr,
                                                      input logic [DATA_W-1:0] wdata);
      access_result_type r;
      logic [63:0]       off;
      int                nbytes;
      r.ok        = 1'b0;
      r.read_data = '0;
      nbytes      = 1 << code;
      if (addr >= base_img) begin
         // window end may lie above 4G, so compare in 64 bits
         off = 64'(addr - base_img);
         if (off + 64'(nbytes) <= 64'(MEM_BYTES)) begin
            r.ok = 1'b1;
            for (int i = 0; i < nbytes; i++) begin
               if (cmd == CMD_WRITE)
                  store_img[int'(off) + i] = wdata[8*i +: 8];
               else
                  r.read_data[8*i +: 8] = store_img[int'(off) + i];
            end
         end
      end
      return r;
   endfunction

   function automatic void note_error(input string msg);
      if (err_cnt < 10)
         $display("%0t ns checker: %s", $time, msg);
      err_cnt++;
   endfunction

   always @(posedge clock) begin
      access_result_type want;
      if (reset) begin
         expected_rsp_q.delete();
         foreach (store_img[i]) store_img[i] = 8'h00;
         base_img = '0;
      end else begin
         if (rsp_valid) begin
            if (expected_rsp_q.size() == 0) begin
               note_error("response with no request outstanding");
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_ok !== want.ok)
                  note_error($sformatf("ok %b, expected %b", rsp_ok, want.ok));
               if (rsp_read_data !== want.read_data)
                  note_error($sformatf("read_data %h, expected %h",
                                       rsp_read_data, want.read_data));
               chk_cnt++;
            end
         end
         if (start && !busy)
            expected_rsp_q.push_back(apply_access(req_cmd, req_width_code,
                                                  req_address, req_write_data));
         if (psel && penable && pready && paddr == BASE_OFS) begin
            if (pwrite)
               base_img = pwdata;
            else if (prdata !== base_img)
               note_error($sformatf("base read %h, expected %h", prdata, base_img));
         end
      end
      n_errors  <= err_cnt;
      n_pending <= expected_rsp_q.size();
      n_checked <= chk_cnt;
   end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import sps_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] BASE_OFS = {REG_BASE_ADDRESS, 2'b00};
   localparam int                    N_PHASES = 7;

   logic                  clock          = 1'b0;
   logic                  reset          = 1'b1;
   logic                  start          = 1'b0;
   logic                  busy;
   logic                  req_cmd        = CMD_READ;
   logic [1:0]            req_width_code = WC_1B;
   logic [ADDR_W-1:0]     req_address    = '0;
   logic [DATA_W-1:0]     req_write_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ok;
   logic [DATA_W-1:0]     rsp_read_data;
   logic                  psel           = 1'b0;
   logic                  penable        = 1'b0;
   logic                  pwrite         = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr          = '0;
   logic [CSR_DATA_W-1:0] pwdata         = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int n_errors;
   int n_pending;
   int n_checked;
   int n_sent      = 0;
   int n_windows   = 1;   // reset value of the base counts as the first setting

   // 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   byte_addressed_scratchpad_ram u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_cmd        (req_cmd),
      .req_width_code (req_width_code),
      .req_address    (req_address),
      .req_write_data (req_write_data),
      .rsp_valid      (rsp_valid),
      .rsp_ok         (rsp_ok),
      .rsp_read_data  (rsp_read_data),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   tb_scratchpad_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_cmd        (req_cmd),
      .req_width_code (req_width_code),
      .req_address    (req_address),
      .req_write_data (req_write_data),
      .rsp_valid      (rsp_valid),
      .rsp_ok         (rsp_ok),
      .rsp_read_data  (rsp_read_data),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .n_errors       (n_errors),
      .n_pending      (n_pending),
      .n_checked      (n_checked)
   );

   // One request transfer. start stays high on return so back-to-back calls
   // give one request per cycle; the transfer edge is the first one with
   // busy low (busy also covers the zero sweep after reset).
   task automatic send(input logic              cmd,
                       input logic [1:0]        code,
                       input logic [ADDR_W-1:0] addr,
                       input logic [DATA_W-1:0] wdata);
      req_cmd        <= cmd;
      req_width_code <= code;
      req_address    <= addr;
      req_write_data <= wdata;
      start          <= 1'b1;
      do @(posedge clock); while (busy);
      n_sent++;
   endtask

   // sender idle; request fields carry junk the block must ignore
   task automatic idle_cycles(input int n);
      start          <= 1'b0;
      req_cmd        <= $urandom_range(0, 1);
      req_width_code <= $urandom_range(0, 3);
      req_address    <= $urandom;
      req_write_data <= {$urandom, $urandom};
      repeat (n) @(posedge clock);
   endtask

   // hold off until every outstanding response has come back, then let the
   // pipeline settle before touching the CSR
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (n_pending != 0);
      repeat (6) @(posedge clock);
   endtask

   // APB setup + access; the checker watches reads and compares prdata
   task automatic csr_access(input logic wr, input logic [CSR_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= BASE_OFS;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic set_base(input logic [ADDR_W-1:0] value);
      drain();
      csr_access(1'b1, value);
      csr_access(1'b0, '0);
      n_windows++;
   endtask

   initial begin
      logic [ADDR_W-1:0] phase_base [N_PHASES];
      int                phase_len  [N_PHASES];
      logic [ADDR_W-1:0] win_base;
      logic [ADDR_W-1:0] off;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] wdata;
      logic              cmd;
      logic [1:0]        code;
      logic              idle_on;
      int                sel;

      // window placements: arbitrary odd base, window ending exactly at 4G,
      // window straddling 4G, window starting at the last byte, a random
      // base, upper half, and back to zero for the final streaming phase
      phase_base = '{32'h0001_2345, 32'hFFFF_C000, 32'hFFFF_E003, 32'hFFFF_FFFF,
                     32'h0000_0000, 32'h8000_0000, 32'h0000_0000};
      phase_len  = '{250, 250, 200, 60, 250, 220, 220};
      phase_base[4] = $urandom;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // base must read back as zero after reset
      csr_access(1'b0, '0);

      // ---- directed part, base 0 ----
      send(CMD_WRITE, WC_8B, 32'd0, 64'h0123_4567_89AB_CDEF);
      send(CMD_READ,  WC_8B, 32'd0, 64'd0);
      send(CMD_READ,  WC_1B, 32'd7, 64'd0);
      send(CMD_READ,  WC_2B, 32'd3, 64'd0);
      send(CMD_READ,  WC_4B, 32'd5, 64'd0);          // crosses a bank row
      send(CMD_WRITE, WC_2B, 32'd6, 64'hFFFF_FFFF_FFFF_A55A); // only low 2 bytes land
      send(CMD_READ,  WC_8B, 32'd1, 64'd0);          // unaligned 8-byte read
      send(CMD_WRITE, WC_8B, MEM_BYTES - 8, '1);
      send(CMD_WRITE, WC_8B, MEM_BYTES - 7, 64'd0);  // crosses window top: nothing written
      send(CMD_READ,  WC_8B, MEM_BYTES - 8, 64'd0);
      send(CMD_READ,  WC_1B, MEM_BYTES - 1, 64'd0);
      send(CMD_READ,  WC_2B, MEM_BYTES - 1, 64'd0);  // rejected
      send(CMD_READ,  WC_1B, MEM_BYTES, 64'd0);      // first byte past the window
      send(CMD_WRITE, WC_4B, 32'hFFFF_FFFF, 64'd0);
      send(CMD_READ,  WC_8B, 32'hFFFF_FFF8, 64'd0);
      send(CMD_WRITE, WC_1B, MEM_BYTES - 1, 64'd0);
      send(CMD_READ,  WC_8B, MEM_BYTES - 8, 64'd0);

      // ---- directed part, base moved up: below-base and edge accesses ----
      set_base(32'h0000_1000);
      send(CMD_READ,  WC_8B, 32'h0000_1000, 64'd0);
      send(CMD_READ,  WC_1B, 32'h0000_0FFF, 64'd0);  // one byte below base
      send(CMD_WRITE, WC_8B, 32'h0000_1000 + MEM_BYTES - 8, 64'd0);
      send(CMD_READ,  WC_8B, 32'h0000_1000 + MEM_BYTES - 4, 64'd0);
      send(CMD_READ,  WC_4B, 32'h0000_1000 + MEM_BYTES - 4, 64'd0);

      // ---- random part ----
      // Offsets cluster at the bottom and top of the window so reads hit
      // bytes written earlier and spans straddle the top edge; the rest are
      // spread over the whole store, just below base, or fully random.
      idle_on = 1'b0;
      for (int p = 0; p < N_PHASES; p++) begin
         set_base(phase_base[p]);
         win_base = phase_base[p];
         for (int k = 0; k < phase_len[p]; k++) begin
            if (k % 32 == 0)
               idle_on = ($urandom_range(0, 2) != 0);
            // last phase streams with no idle cycles
            if (p != N_PHASES - 1 && idle_on && $urandom_range(0, 3) == 0)
               idle_cycles($urandom_range(1, 11));
            sel = $urandom_range(0, 99);
            if (sel < 35)
               off = $urandom_range(0, 63);
            else if (sel < 60)
               off = MEM_BYTES - 72 + $urandom_range(0, 79);
            else if (sel < 85)
               off = $urandom_range(0, MEM_BYTES - 1);
            else if (sel < 92)
               off = -$urandom_range(1, 8);
            else
               off = $urandom - win_base;
            addr = win_base + off;
            cmd  = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
            case ($urandom_range(0, 3))
               0:       code = WC_1B;
               1:       code = WC_2B;
               2:       code = WC_4B;
               default: code = WC_8B;
            endcase
            sel = $urandom_range(0, 19);
            if (sel == 0)
               wdata = '0;
            else if (sel == 1)
               wdata = '1;
            else
               wdata = {$urandom, $urandom};
            send(cmd, code, addr, wdata);
         end
      end

      drain();

      $display("%0d requests sent, %0d responses checked, %0d base settings",
               n_sent, n_checked, n_windows);
      $display("covered all sizes, unaligned spans, window edges and bases near 4G");
      if (n_errors == 0 && n_pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
